### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock, off while reset is low
`define CFAP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cfap assertion failed");

// same-cycle implication
`define CFAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    `CFAP_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

### rtl/cfap_pkg.sv
// shared types, codes and the crc step for the command framer and answer parser
package cfap_pkg;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_ANSWER = 2'd2;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_CHARGE = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [7:0] ASCII_T    = 8'h54;
    localparam logic [7:0] ASCII_Q    = 8'h51;
    localparam logic [7:0] ASCII_W    = 8'h57;
    localparam logic [7:0] ASCII_R    = 8'h52;
    localparam logic [7:0] ASCII_A    = 8'h41;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_ONE  = 8'h31;
    localparam logic [7:0] WR_LEN     = 8'h02;
    localparam logic [7:0] RD_LEN     = 8'h00;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // parser phases
    localparam logic [3:0] PH_HDR0    = 4'd0;
    localparam logic [3:0] PH_HDR1    = 4'd1;
    localparam logic [3:0] PH_HDR2    = 4'd2;
    localparam logic [3:0] PH_HDR3    = 4'd3;
    localparam logic [3:0] PH_LEN     = 4'd4;
    localparam logic [3:0] PH_DIG0    = 4'd5;
    localparam logic [3:0] PH_DIG3    = 4'd8;
    localparam logic [3:0] PH_CHARGE  = 4'd9;
    localparam logic [3:0] PH_DISCARD = 4'd10;

    localparam logic [3:0] WR_BODY_LEN = 4'd7;
    localparam logic [3:0] RD_BODY_LEN = 4'd5;

    typedef struct packed {
        logic start;
        logic emit_frame;
        logic emit_charge;
        logic emit_status;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic have_charge;
        logic frame_done;
        logic item_last;
    } t_dp_status;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/cfap_cmd_if.sv
// input channel: opcode and received byte
interface cfap_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic       rx_last;

    modport source (output valid, output opcode, output rx_byte, output rx_last, input ready);
    modport sink   (input valid, input opcode, input rx_byte, input rx_last, output ready);
endinterface

### rtl/cfap_rsp_if.sv
// output channel: transmit, charge and status results
interface cfap_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;
    logic       parse_error;
    logic       pause_flag;
    logic       wheels_flag;
    logic       run_status;
    logic       run_mode;

    modport source (output valid, output kind, output data_byte, output last,
                    output parse_error, output pause_flag, output wheels_flag,
                    output run_status, output run_mode, input ready);
    modport sink   (input valid, input kind, input data_byte, input last,
                    input parse_error, input pause_flag, input wheels_flag,
                    input run_status, input run_mode, output ready);
endinterface

### rtl/command_framer_and_answer_parser.sv
// top level of the command framer and answer parser
`include "assert_macros.svh"

// Builds write and read command frames (CRC-16, poly 0x1021, init 0xFFFF, sent
// high byte first) and parses answer bytes from the remote unit. An input beat
// is taken whenever the controller is idle; its result beats then leave
// through a single output register at one per cycle while the sink is
// ready. An answer byte yields 0, 1 or 2 results. A write frame has 9 bytes
// and a read frame 7, body plus two CRC bytes, and the byte-wide CRC step
// runs once per body byte. A new beat is accepted while the last result beat
// of the previous item still waits in the output register.
// The device id register is written through i_cfg_we / i_cfg_data.
module command_framer_and_answer_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    cfap_cmd_if.sink   i_cmd,
    cfap_rsp_if.source o_rsp
);
    import cfap_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       ready;
    logic [2:0] emits;
    logic       st_beat;

    cfap_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_cmd.valid),
        .i_opcode (i_cmd.opcode),
        .i_rx_last(i_cmd.rx_last),
        .i_status (dp_status),
        .o_ready  (ready),
        .o_cmd    (dp_cmd)
    );

    cfap_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_opcode     (i_cmd.opcode),
        .i_rx_byte    (i_cmd.rx_byte),
        .i_rx_last    (i_cmd.rx_last),
        .i_rsp_ready  (o_rsp.ready),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .o_rsp_valid  (o_rsp.valid),
        .o_kind       (o_rsp.kind),
        .o_data_byte  (o_rsp.data_byte),
        .o_last       (o_rsp.last),
        .o_parse_error(o_rsp.parse_error),
        .o_pause_flag (o_rsp.pause_flag),
        .o_wheels_flag(o_rsp.wheels_flag),
        .o_run_status (o_rsp.run_status),
        .o_run_mode   (o_rsp.run_mode)
    );

    assign i_cmd.ready = ready;
    assign emits       = {dp_cmd.emit_frame, dp_cmd.emit_charge, dp_cmd.emit_status};
    assign st_beat     = o_rsp.valid && o_rsp.kind == KIND_STATUS;

    // no result beat is produced in the cycle an item is taken
    `CFAP_ASSERT_IMP(a_no_emit_at_accept, i_clk, i_rst_n, ready, !(|emits))
    `CFAP_ASSERT(a_one_emit, i_clk, i_rst_n, $onehot0(emits))
    // a beat is only loaded when the output register is free
    `CFAP_ASSERT_IMP(a_emit_slot, i_clk, i_rst_n, |emits, dp_status.slot_free)
    `CFAP_ASSERT_IMP(a_status_last, i_clk, i_rst_n, st_beat, o_rsp.last && o_rsp.data_byte == 8'h00)

endmodule

### rtl/cfap_ctrl.sv
// controller state machine: accepts items and sequences result beats
module cfap_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [1:0]           i_opcode,
    input  logic                 i_rx_last,
    input  cfap_pkg::t_dp_status i_status,
    output logic                 o_ready,
    output cfap_pkg::t_dp_cmd    o_cmd
);
    import cfap_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FRAME  = 4'b0010,
        S_CHARGE = 4'b0100,
        S_STATUS = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    unique case (i_opcode)
                        OP_WRITE, OP_READ: begin
                            n_state = S_FRAME;
                        end
                        OP_ANSWER: begin
                            if (i_status.have_charge) begin
                                n_state = S_CHARGE;
                            end else if (i_rx_last) begin
                                n_state = S_STATUS;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FRAME: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_frame = 1'b1;
                    if (i_status.frame_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CHARGE: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_charge = 1'b1;
                    n_state = i_status.item_last ? S_STATUS : S_IDLE;
                end
            end
            S_STATUS: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/cfap_dp.sv
// datapath: parser state, frame builder with crc, stored flags and output register
module cfap_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data,
    input  logic [1:0]           i_opcode,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_rx_last,
    input  logic                 i_rsp_ready,
    input  cfap_pkg::t_dp_cmd    i_cmd,
    output cfap_pkg::t_dp_status o_status,
    output logic                 o_rsp_valid,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_data_byte,
    output logic                 o_last,
    output logic                 o_parse_error,
    output logic                 o_pause_flag,
    output logic                 o_wheels_flag,
    output logic                 o_run_status,
    output logic                 o_run_mode
);
    import cfap_pkg::*;

    logic [7:0]  r_device_id;
    logic        r_pause, r_wheels, r_status, r_mode;
    logic [3:0]  r_phase;
    logic [7:0]  r_charge_left;
    logic        r_bad;
    logic [3:0]  r_digits;

    // item captured at accept
    logic        r_wr;
    logic [3:0]  r_idx;
    logic [15:0] r_crc;
    logic [7:0]  r_byte;
    logic        r_last_in;
    logic        r_err;
    logic [3:0]  r_commit;

    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_data;
    logic        r_out_last, r_out_err;
    logic [3:0]  r_out_flags;

    logic [3:0]  n_phase;
    logic [7:0]  n_charge_left;
    logic        n_bad;
    logic [3:0]  n_digits;
    logic        have_charge;
    logic        ans_err;
    logic [3:0]  dig_off;
    logic [1:0]  dig_idx;

    logic [3:0]  frame_len;
    logic [7:0]  frame_byte;
    logic        in_body;
    logic        emit_any;
    logic [3:0]  cur_flags;

    assign cur_flags = {r_mode, r_status, r_wheels, r_pause};
    assign dig_off   = r_phase - PH_DIG0;
    assign dig_idx   = dig_off[1:0];

    always_comb begin
        n_phase       = r_phase;
        n_charge_left = r_charge_left;
        n_bad         = r_bad;
        n_digits      = r_digits;
        have_charge   = 1'b0;
        case (r_phase) inside
            PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
                if ((r_phase == PH_HDR0 && i_rx_byte == ASCII_T) ||
                    (r_phase == PH_HDR1 && i_rx_byte == ASCII_Q) ||
                    (r_phase == PH_HDR2 && i_rx_byte == r_device_id) ||
                    (r_phase == PH_HDR3 && i_rx_byte == ASCII_A)) begin
                    n_phase = r_phase + 4'd1;
                end else begin
                    n_bad   = 1'b1;
                    n_phase = PH_DISCARD;
                end
            end
            PH_LEN: begin
                n_charge_left = (i_rx_byte >= 8'd4) ? i_rx_byte - 8'd4 : 8'd0;
                n_phase       = PH_DIG0;
            end
            [PH_DIG0:PH_DIG3]: begin
                if (i_rx_byte == ASCII_ONE) begin
                    n_digits[dig_idx] = 1'b1;
                end else if (i_rx_byte != ASCII_ZERO) begin
                    n_bad = 1'b1;
                end
                n_phase = r_phase + 4'd1;
            end
            PH_CHARGE: begin
                if (r_charge_left != 8'd0) begin
                    n_charge_left = r_charge_left - 8'd1;
                    have_charge   = 1'b1;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        ans_err = n_bad || (n_phase < PH_CHARGE);
    end

    assign frame_len = r_wr ? WR_BODY_LEN : RD_BODY_LEN;
    assign in_body   = r_idx < frame_len;

    always_comb begin
        if (in_body) begin
            case (r_idx)
                4'd0:    frame_byte = ASCII_T;
                4'd1:    frame_byte = ASCII_Q;
                4'd2:    frame_byte = r_device_id;
                4'd3:    frame_byte = r_wr ? ASCII_W : ASCII_R;
                4'd4:    frame_byte = r_wr ? WR_LEN : RD_LEN;
                4'd5:    frame_byte = ASCII_ZERO | {7'd0, r_pause};
                4'd6:    frame_byte = ASCII_ZERO | {7'd0, r_wheels};
                default: frame_byte = 8'h00;
            endcase
        end else if (r_idx == frame_len) begin
            frame_byte = r_crc[15:8];
        end else begin
            frame_byte = r_crc[7:0];
        end
    end

    assign emit_any = i_cmd.emit_frame || i_cmd.emit_charge || i_cmd.emit_status;

    assign o_status.slot_free   = !r_out_valid || i_rsp_ready;
    assign o_status.have_charge = have_charge;
    assign o_status.frame_done  = r_idx == 4'(frame_len + 4'd1);
    assign o_status.item_last   = r_last_in;

    // config, parser state, stored flags and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id   <= 8'h00;
            r_pause       <= 1'b0;
            r_wheels      <= 1'b0;
            r_status      <= 1'b0;
            r_mode        <= 1'b0;
            r_phase       <= PH_HDR0;
            r_charge_left <= 8'h00;
            r_bad         <= 1'b0;
            r_digits      <= 4'h0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_device_id <= i_cfg_data;
            end
            if (i_cmd.start && i_opcode == OP_ANSWER) begin
                if (i_rx_last) begin
                    r_phase       <= PH_HDR0;
                    r_charge_left <= 8'h00;
                    r_bad         <= 1'b0;
                    r_digits      <= 4'h0;
                end else begin
                    r_phase       <= n_phase;
                    r_charge_left <= n_charge_left;
                    r_bad         <= n_bad;
                    r_digits      <= n_digits;
                end
            end
            // digits commit with the status beat when the answer had no error
            if (i_cmd.emit_status && !r_err) begin
                r_pause  <= r_commit[0];
                r_wheels <= r_commit[1];
                r_status <= r_commit[2];
                r_mode   <= r_commit[3];
            end
            if (emit_any) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_wr      <= i_opcode == OP_WRITE;
            r_idx     <= 4'd0;
            r_crc     <= CRC_INIT;
            r_byte    <= i_rx_byte;
            r_last_in <= i_rx_last;
            r_err     <= ans_err;
            r_commit  <= n_digits;
        end
        if (i_cmd.emit_frame) begin
            r_idx <= r_idx + 4'd1;
            if (in_body) begin
                r_crc <= crc16_byte(r_crc, frame_byte);
            end
        end
        if (i_cmd.emit_frame) begin
            r_kind      <= KIND_TX;
            r_data      <= frame_byte;
            r_out_last  <= o_status.frame_done;
            r_out_err   <= 1'b0;
            r_out_flags <= cur_flags;
        end else if (i_cmd.emit_charge) begin
            r_kind      <= KIND_CHARGE;
            r_data      <= r_byte;
            r_out_last  <= !r_last_in;
            r_out_err   <= 1'b0;
            r_out_flags <= cur_flags;
        end else if (i_cmd.emit_status) begin
            r_kind      <= KIND_STATUS;
            r_data      <= 8'h00;
            r_out_last  <= 1'b1;
            r_out_err   <= r_err;
            r_out_flags <= r_err ? cur_flags : r_commit;
        end
    end

    assign o_rsp_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_data_byte   = r_data;
    assign o_last        = r_out_last;
    assign o_parse_error = r_out_err;
    assign o_pause_flag  = r_out_flags[0];
    assign o_wheels_flag = r_out_flags[1];
    assign o_run_status  = r_out_flags[2];
    assign o_run_mode    = r_out_flags[3];

endmodule
